// ===== rtl/core/grouped_circular_undo_stack_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the grouped circular undo stack
// Shared forms for the concurrent checks of the block.
// ---------------------------------------------------------------------------
`ifndef GROUPED_CIRCULAR_UNDO_STACK_ASSERT_SVH
`define GROUPED_CIRCULAR_UNDO_STACK_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define GCUS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define GCUS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/gcus_pkg.sv =====
// ---------------------------------------------------------------------------
// gcus_pkg
// Types, codes and constants of the grouped circular undo stack.
// ---------------------------------------------------------------------------
package gcus_pkg;

    localparam int DEPTH_DEF = 1024;
    localparam int WORD_W    = 32;
    localparam int SIZE_W    = 11;
    localparam int FQ_DEPTH  = 2;

    localparam logic [1:0] REQ_PUSH  = 2'd0;
    localparam logic [1:0] REQ_POP   = 2'd1;
    localparam logic [1:0] REQ_WIPE  = 2'd2;
    localparam logic [1:0] REQ_BEGIN = 2'd3;

    localparam logic [2:0] ST_DONE     = 3'd0;
    localparam logic [2:0] ST_IGNORED  = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_OVERFLOW = 3'd3;
    localparam logic [2:0] ST_INVALID  = 3'd4;

    localparam logic [1:0] CFG_USED_SIZE   = 2'd0;
    localparam logic [1:0] CFG_EMPTY_CODE  = 2'd1;
    localparam logic [1:0] CFG_MARKER_CODE = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] word_a;
        logic signed [31:0] word_b;
        logic signed [31:0] word_c;
        logic signed [31:0] word_d;
        logic signed [31:0] word_e;
        logic signed [31:0] rec_value;
    } req_t;

    typedef struct packed {
        logic signed [31:0] out_a;
        logic signed [31:0] out_b;
        logic signed [31:0] out_c;
        logic signed [31:0] out_d;
        logic signed [31:0] out_e;
        logic signed [31:0] out_value;
        logic [2:0]         status;
    } res_t;

    typedef struct packed {
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] d;
        logic [WORD_W-1:0] e;
        logic [WORD_W-1:0] value;
    } rec_t;

    typedef struct packed {
        logic [1:0] op;
        rec_t       rec;
        logic       is_empty;
        logic       is_marker;
    } cmd_t;

    typedef struct packed {
        logic [WORD_W-1:0] empty_code;
        logic [WORD_W-1:0] marker_code;
        logic              init_busy;
    } back_view_t;

endpackage

// ===== rtl/core/grouped_circular_undo_stack.sv =====
// ---------------------------------------------------------------------------
// grouped_circular_undo_stack
// Circular history of six-word records, grouped into turns by marker records.
// ---------------------------------------------------------------------------
// A begin-turn or an empty-stack pop is answered from idle, a pop passes S_POP
// and a plain push passes S_PCHK, S_PTGT and S_WRITE, as the record store has
// a registered read. A push that overwrites an old turn erases one slot per
// cycle in S_ERASE. A wipe, a write of used_size and the clearing pass
// after reset each clear all DEPTH slots; full stays high during the reset pass.
module grouped_circular_undo_stack #(
    parameter int DEPTH = gcus_pkg::DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  gcus_pkg::req_t  req,
    output logic            empty,
    input  logic            pop,
    output gcus_pkg::res_t  res,
    input  logic            cfg_we,
    input  logic [1:0]      cfg_index,
    input  logic [31:0]     cfg_data
);
    import gcus_pkg::*;
    `include "grouped_circular_undo_stack_assert.svh"

    logic       cmd_valid;
    logic       cmd_take;
    cmd_t       cmd;
    back_view_t view;

    gcus_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req       (req),
        .view      (view),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    gcus_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .view      (view),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .empty     (empty),
        .pop       (pop),
        .res       (res)
    );

    `GCUS_ASSERT_SAME(a_init_blocks, view.init_busy, full && !cmd_take, "Item taken during clearing pass.")
    `GCUS_ASSERT_SAME(a_status_range, !empty, res.status <= ST_INVALID, "Result status out of range.")
    `GCUS_ASSERT_SAME(a_nonpop_zero, !empty && (res.status == ST_IGNORED || res.status == ST_OVERFLOW || res.status == ST_INVALID), res.out_a == 0 && res.out_value == 0, "Non-pop result carries data.")
    `GCUS_ASSERT_NEXT(a_take_fills, cmd_take && !cmd_valid, 1'b0, "Command taken from an empty queue.")

endmodule

// ===== rtl/core/gcus_front.sv =====
// ---------------------------------------------------------------------------
// gcus_front
// Accepts request items, classifies the first word and queues the commands.
// ---------------------------------------------------------------------------
module gcus_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  gcus_pkg::req_t  req,
    input  gcus_pkg::back_view_t view,
    output logic            cmd_valid,
    output gcus_pkg::cmd_t  cmd,
    input  logic            cmd_take
);
    import gcus_pkg::*;

    cmd_t       ent_reg [FQ_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       accept;
    cmd_t       new_cmd;

    assign full      = (cnt_reg == 2'(FQ_DEPTH)) || view.init_busy;
    assign accept    = push && !full;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = ent_reg[rd_ptr_reg];

    always_comb
    begin
        new_cmd.op        = req.req_type;
        new_cmd.rec.a     = req.word_a;
        new_cmd.rec.b     = req.word_b;
        new_cmd.rec.c     = req.word_c;
        new_cmd.rec.d     = req.word_d;
        new_cmd.rec.e     = req.word_e;
        new_cmd.rec.value = req.rec_value;
        new_cmd.is_empty  = (req.word_a == view.empty_code);
        new_cmd.is_marker = (req.word_a == view.marker_code);
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (accept)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (cmd_take && cmd_valid)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (accept && !(cmd_take && cmd_valid))
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!accept && cmd_take && cmd_valid)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ent_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

// ===== rtl/core/gcus_back.sv =====
// ---------------------------------------------------------------------------
// gcus_back
// Executes queued commands against the record store and holds the result.
// ---------------------------------------------------------------------------
module gcus_back #(
    parameter int DEPTH = gcus_pkg::DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    input  gcus_pkg::cmd_t  cmd,
    output logic            cmd_take,
    output gcus_pkg::back_view_t view,
    input  logic            cfg_we,
    input  logic [1:0]      cfg_index,
    input  logic [31:0]     cfg_data,
    output logic            empty,
    input  logic            pop,
    output gcus_pkg::res_t  res
);
    import gcus_pkg::*;

    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int USED_RST = (DEPTH < 1024) ? DEPTH : 1024;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SWEEP = 3'd1;
    localparam logic [2:0] S_POP   = 3'd2;
    localparam logic [2:0] S_PCHK  = 3'd3;
    localparam logic [2:0] S_PTGT  = 3'd4;
    localparam logic [2:0] S_ERASE = 3'd5;
    localparam logic [2:0] S_WRITE = 3'd6;

    rec_t mem [DEPTH];
    rec_t rd_q;

    logic [2:0]        state_reg, state_next;
    logic [IDX_W-1:0]  top_reg, top_next;
    logic              top_empty_reg, top_empty_next;
    logic [CNT_W-1:0]  turn_reg, turn_next;
    logic              rec_on_reg, rec_on_next;
    logic [CNT_W-1:0]  used_reg, used_next;
    logic [WORD_W-1:0] empty_reg, empty_next;
    logic [WORD_W-1:0] marker_reg, marker_next;
    logic [IDX_W-1:0]  sweep_idx_reg, sweep_idx_next;
    logic [WORD_W-1:0] sweep_code_reg, sweep_code_next;
    logic              sweep_req_reg, sweep_req_next;
    logic              init_reg, init_next;
    logic [IDX_W-1:0]  walk_idx_reg, walk_idx_next;
    logic [CNT_W-1:0]  walk_n_reg, walk_n_next;
    logic [IDX_W-1:0]  tgt_reg, tgt_next;
    cmd_t              cmd_reg, cmd_next;
    logic              res_valid_reg, res_valid_next;
    res_t              res_reg, res_next;

    logic              mem_we, mem_re;
    logic [IDX_W-1:0]  mem_waddr, mem_raddr;
    rec_t              mem_wdata;
    rec_t              clear_rec;
    logic [CNT_W-1:0]  step_up;
    logic [31:0]       size_clamp;

    assign view.empty_code  = empty_reg;
    assign view.marker_code = marker_reg;
    assign view.init_busy   = init_reg;
    assign empty            = !res_valid_reg;
    assign res              = res_reg;
    assign cmd_take = (state_reg == S_IDLE) && !sweep_req_reg && cmd_valid && !res_valid_reg;

    always_comb
    begin
        clear_rec       = '0;
        clear_rec.a     = empty_reg;
        clear_rec.b     = empty_reg;
        clear_rec.c     = empty_reg;
        clear_rec.d     = empty_reg;
        clear_rec.e     = empty_reg;
        size_clamp = {21'd0, cfg_data[SIZE_W-1:0]};
        if (size_clamp == 32'd0)
        begin
            size_clamp = 32'd1;
        end
        if (size_clamp > 32'(DEPTH))
        begin
            size_clamp = 32'(DEPTH);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        top_next        = top_reg;
        top_empty_next  = top_empty_reg;
        turn_next       = turn_reg;
        rec_on_next     = rec_on_reg;
        used_next       = used_reg;
        empty_next      = empty_reg;
        marker_next     = marker_reg;
        sweep_idx_next  = sweep_idx_reg;
        sweep_code_next = sweep_code_reg;
        sweep_req_next  = sweep_req_reg;
        init_next       = init_reg;
        walk_idx_next   = walk_idx_reg;
        walk_n_next     = walk_n_reg;
        tgt_next        = tgt_reg;
        cmd_next        = cmd_reg;
        res_valid_next  = res_valid_reg;
        res_next        = res_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_waddr       = '0;
        mem_raddr       = '0;
        mem_wdata       = clear_rec;
        step_up         = '0;

        if (pop && res_valid_reg)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (sweep_req_reg)
                begin
                    sweep_req_next = 1'b0;
                    sweep_idx_next = '0;
                    state_next     = S_SWEEP;
                end
                else if (cmd_take)
                begin
                    cmd_next = cmd;
                    res_next = '0;
                    unique case (cmd.op)
                        REQ_BEGIN:
                        begin
                            rec_on_next    = 1'b1;
                            turn_next      = '0;
                            res_next.status = ST_DONE;
                            res_valid_next = 1'b1;
                        end
                        REQ_WIPE:
                        begin
                            sweep_code_next = empty_reg;
                            top_empty_next  = 1'b1;
                            turn_next       = '0;
                            sweep_idx_next  = '0;
                            state_next      = S_SWEEP;
                            res_next.status = ST_DONE;
                            res_valid_next  = 1'b1;
                        end
                        REQ_POP:
                        begin
                            if (top_empty_reg)
                            begin
                                res_next.out_a  = empty_reg;
                                res_next.status = ST_EMPTY;
                                res_valid_next  = 1'b1;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = top_reg;
                                state_next = S_POP;
                            end
                        end
                        default:
                        begin
                            if (!rec_on_reg)
                            begin
                                res_next.status = ST_IGNORED;
                                res_valid_next  = 1'b1;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = top_reg;
                                state_next = S_PCHK;
                            end
                        end
                    endcase
                end
            end
            S_SWEEP:
            begin
                mem_we          = 1'b1;
                mem_waddr       = sweep_idx_reg;
                mem_wdata       = '0;
                mem_wdata.a     = sweep_code_reg;
                mem_wdata.b     = sweep_code_reg;
                mem_wdata.c     = sweep_code_reg;
                mem_wdata.d     = sweep_code_reg;
                mem_wdata.e     = sweep_code_reg;
                if (sweep_idx_reg == IDX_W'(DEPTH - 1))
                begin
                    init_next  = 1'b0;
                    state_next = S_IDLE;
                end
                else
                begin
                    sweep_idx_next = sweep_idx_reg + 1'b1;
                end
            end
            S_POP:
            begin
                res_next.out_a     = rd_q.a;
                res_next.out_b     = rd_q.b;
                res_next.out_c     = rd_q.c;
                res_next.out_d     = rd_q.d;
                res_next.out_e     = rd_q.e;
                res_next.out_value = rd_q.value;
                res_valid_next     = 1'b1;
                state_next         = S_IDLE;
                if (rd_q.a == empty_reg)
                begin
                    res_next.status = ST_EMPTY;
                end
                else
                begin
                    res_next.status = ST_DONE;
                    mem_we          = 1'b1;
                    mem_waddr       = top_reg;
                    if (top_reg == '0)
                    begin
                        top_next = IDX_W'(used_reg - 1'b1);
                    end
                    else
                    begin
                        top_next = top_reg - 1'b1;
                    end
                end
            end
            S_PCHK:
            begin
                if (cmd_reg.is_marker && (top_empty_reg || rd_q.a == marker_reg
                    || rd_q.a == empty_reg))
                begin
                    res_next.status = ST_IGNORED;
                    res_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
                else if (cmd_reg.is_empty || turn_reg >= used_reg)
                begin
                    res_next.status = cmd_reg.is_empty ? ST_INVALID : ST_OVERFLOW;
                    res_valid_next  = 1'b1;
                    sweep_code_next = empty_reg;
                    top_empty_next  = 1'b1;
                    turn_next       = '0;
                    rec_on_next     = 1'b0;
                    sweep_idx_next  = '0;
                    state_next      = S_SWEEP;
                end
                else
                begin
                    step_up = top_empty_reg ? '0 : (CNT_W'(top_reg) + 1'b1);
                    if (step_up >= used_reg)
                    begin
                        step_up = '0;
                    end
                    tgt_next       = IDX_W'(step_up);
                    top_next       = IDX_W'(step_up);
                    top_empty_next = 1'b0;
                    mem_re         = 1'b1;
                    mem_raddr      = IDX_W'(step_up);
                    state_next     = S_PTGT;
                end
            end
            S_PTGT:
            begin
                if (rd_q.a != empty_reg)
                begin
                    walk_idx_next = tgt_reg;
                    walk_n_next   = '0;
                    state_next    = S_ERASE;
                end
                else
                begin
                    state_next = S_WRITE;
                end
            end
            S_ERASE:
            begin
                mem_we    = 1'b1;
                mem_waddr = walk_idx_reg;
                if (rd_q.a == marker_reg || (walk_n_reg + 1'b1) >= used_reg)
                begin
                    state_next = S_WRITE;
                end
                else
                begin
                    step_up = CNT_W'(walk_idx_reg) + 1'b1;
                    if (step_up >= used_reg)
                    begin
                        step_up = '0;
                    end
                    walk_idx_next = IDX_W'(step_up);
                    walk_n_next   = walk_n_reg + 1'b1;
                    mem_re        = 1'b1;
                    mem_raddr     = IDX_W'(step_up);
                end
            end
            S_WRITE:
            begin
                mem_we          = 1'b1;
                mem_waddr       = tgt_reg;
                mem_wdata       = cmd_reg.rec;
                turn_next       = turn_reg + 1'b1;
                res_next.status = ST_DONE;
                res_valid_next  = 1'b1;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_USED_SIZE:
                begin
                    used_next       = CNT_W'(size_clamp);
                    sweep_code_next = empty_reg;
                    sweep_req_next  = 1'b1;
                    top_empty_next  = 1'b1;
                    turn_next       = '0;
                end
                CFG_EMPTY_CODE:  empty_next  = cfg_data;
                CFG_MARKER_CODE: marker_next = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_SWEEP;
            top_reg        <= '0;
            top_empty_reg  <= 1'b1;
            turn_reg       <= '0;
            rec_on_reg     <= 1'b0;
            used_reg       <= CNT_W'(USED_RST);
            empty_reg      <= '1;
            marker_reg     <= {{(WORD_W-1){1'b1}}, 1'b0};
            sweep_idx_reg  <= '0;
            sweep_code_reg <= '1;
            sweep_req_reg  <= 1'b0;
            init_reg       <= 1'b1;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            top_reg        <= top_next;
            top_empty_reg  <= top_empty_next;
            turn_reg       <= turn_next;
            rec_on_reg     <= rec_on_next;
            used_reg       <= used_next;
            empty_reg      <= empty_next;
            marker_reg     <= marker_next;
            sweep_idx_reg  <= sweep_idx_next;
            sweep_code_reg <= sweep_code_next;
            sweep_req_reg  <= sweep_req_next;
            init_reg       <= init_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        walk_idx_reg <= walk_idx_next;
        walk_n_reg   <= walk_n_next;
        tgt_reg      <= tgt_next;
        cmd_reg      <= cmd_next;
        res_reg      <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_q <= mem[mem_raddr];
        end
    end

endmodule
